>>> hw/rtl/shash_pkg.sv
// ----------------------------------------------------------------------------
// shash_pkg
// Shared types, constants and round functions of the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
package shash_pkg;

  typedef logic [31:0] word_t;

  // padding marker byte that follows the last message byte
  localparam logic [7:0] PAD_MARKER = 8'h80;

  // source of the byte shifted into the block register
  typedef enum logic [1:0] {
    BSEL_INPUT = 2'd0,
    BSEL_MARK  = 2'd1,
    BSEL_ZERO  = 2'd2,
    BSEL_LEN   = 2'd3
  } byte_sel_t;

  // controller to datapath commands
  typedef struct packed {
    logic      shift_en;
    byte_sel_t byte_sel;
    logic      load_vars;
    logic      round_en;
    logic [5:0] round;
    logic      update_chain;
    logic      finish;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic count_full;
    logic count_ge_56;
    logic out_busy;
  } dp_status_t;

  function automatic word_t init_word(input logic [2:0] idx);
    word_t v;
    case (idx)
      3'd0: v = 32'h6a09e667;
      3'd1: v = 32'hbb67ae85;
      3'd2: v = 32'h3c6ef372;
      3'd3: v = 32'ha54ff53a;
      3'd4: v = 32'h510e527f;
      3'd5: v = 32'h9b05688c;
      3'd6: v = 32'h1f83d9ab;
      3'd7: v = 32'h5be0cd19;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic word_t round_const(input logic [5:0] t);
    word_t k;
    case (t)
      6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
      default: k = '0;
    endcase
    return k;
  endfunction

  function automatic word_t ror(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t big_sigma0(input word_t x);
    return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction

endpackage

>>> hw/rtl/shash_ctrl.sv
// ----------------------------------------------------------------------------
// shash_ctrl
// Sequencer for byte intake, padding, compression rounds and digest hand-off.
// ----------------------------------------------------------------------------
module shash_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_present,
  input  logic                 in_last,
  output logic                 in_ready,
  input  shash_pkg::dp_status_t status,
  output shash_pkg::dp_cmd_t   cmd
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_PAD    = 6'b000010,
    S_LOAD   = 6'b000100,
    S_ROUNDS = 6'b001000,
    S_UPDATE = 6'b010000,
    S_FINAL  = 6'b100000
  } state_t;

  state_t     state, state_next;
  logic [5:0] round;
  logic       last_pend;
  logic       padding;
  logic       marker_done;
  logic       lenblk;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next       = state;
    cmd              = '0;
    cmd.byte_sel     = shash_pkg::BSEL_INPUT;
    cmd.round        = round;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.shift_en = in_present;
          if (in_present && status.count_full) begin
            state_next = S_LOAD;
          end else if (in_last) begin
            state_next = S_PAD;
          end
        end
      end
      S_PAD: begin
        cmd.shift_en = 1'b1;
        if (!marker_done) begin
          cmd.byte_sel = shash_pkg::BSEL_MARK;
        end else if (lenblk && status.count_ge_56) begin
          cmd.byte_sel = shash_pkg::BSEL_LEN;
        end else begin
          cmd.byte_sel = shash_pkg::BSEL_ZERO;
        end
        if (status.count_full) begin
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.load_vars = 1'b1;
        state_next    = S_ROUNDS;
      end
      S_ROUNDS: begin
        cmd.round_en = 1'b1;
        if (round == 6'd63) begin
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update_chain = 1'b1;
        if (padding) begin
          state_next = lenblk ? S_FINAL : S_PAD;
        end else begin
          state_next = last_pend ? S_PAD : S_IDLE;
        end
      end
      S_FINAL: begin
        if (!status.out_busy) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      round       <= '0;
      last_pend   <= 1'b0;
      padding     <= 1'b0;
      marker_done <= 1'b0;
      lenblk      <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_ROUNDS) begin
        round <= round + 6'd1;
      end
      if (state == S_IDLE && in_valid) begin
        last_pend <= in_last;
      end
      // start of padding for this message
      if (state_next == S_PAD && !padding) begin
        padding     <= 1'b1;
        marker_done <= 1'b0;
        lenblk      <= 1'b0;
      end
      // length fits behind the marker only if the marker lands before byte 56
      if (state == S_PAD && !marker_done) begin
        marker_done <= 1'b1;
        lenblk      <= !status.count_ge_56;
      end
      if (state == S_UPDATE && padding && !lenblk) begin
        lenblk <= 1'b1;
      end
      if (cmd.finish) begin
        last_pend   <= 1'b0;
        padding     <= 1'b0;
        marker_done <= 1'b0;
        lenblk      <= 1'b0;
      end
    end
  end

  a_full_block_loads: assert property (@(posedge clk) disable iff (rst)
    (cmd.shift_en && status.count_full) |=> (state == S_LOAD))
    else $error("full block not followed by compression");

  a_final_after_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINAL) |-> (padding && lenblk && marker_done))
    else $error("digest stage reached before length block");

  a_round_wrapped: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPDATE) |-> (round == 6'd0))
    else $error("round counter out of step");

endmodule

>>> hw/rtl/shash_dp.sv
// ----------------------------------------------------------------------------
// shash_dp
// Block shift register, message schedule, round unit, chaining state and
// digest output buffer.
// ----------------------------------------------------------------------------
module shash_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [7:0]            in_byte,
  input  shash_pkg::dp_cmd_t    cmd,
  output shash_pkg::dp_status_t status,
  output logic                  out_valid,
  input  logic                  out_ready,
  output shash_pkg::word_t      out_word,
  output logic [2:0]            out_index,
  output logic                  out_last
);

  // block register: oldest byte in the top bits, word 0 of the window on top
  logic [511:0]          blk;
  shash_pkg::word_t      vars  [8];
  shash_pkg::word_t      chain [8];
  shash_pkg::word_t      dig   [8];
  logic [5:0]            count;
  logic [63:0]           bitlen;
  logic                  out_busy;
  logic [2:0]            out_idx;

  logic [7:0]            shift_byte;
  logic [63:0]           len_sh;
  shash_pkg::word_t      w_cur, w_new, t1, t2, ch, maj;

  assign len_sh = bitlen << {count[2:0], 3'b000};

  always_comb begin
    case (cmd.byte_sel)
      shash_pkg::BSEL_INPUT: shift_byte = in_byte;
      shash_pkg::BSEL_MARK:  shift_byte = shash_pkg::PAD_MARKER;
      shash_pkg::BSEL_LEN:   shift_byte = len_sh[63:56];
      default:               shift_byte = 8'h00;
    endcase
  end

  assign w_cur = blk[511:480];
  assign w_new = shash_pkg::small_sigma1(blk[63:32]) + blk[223:192]
               + shash_pkg::small_sigma0(blk[479:448]) + w_cur;
  assign ch    = (vars[4] & vars[5]) ^ (~vars[4] & vars[6]);
  assign maj   = (vars[0] & vars[1]) ^ (vars[0] & vars[2]) ^ (vars[1] & vars[2]);
  assign t1    = vars[7] + shash_pkg::big_sigma1(vars[4]) + ch
               + shash_pkg::round_const(cmd.round) + w_cur;
  assign t2    = shash_pkg::big_sigma0(vars[0]) + maj;

  always_ff @(posedge clk) begin
    if (cmd.shift_en) begin
      blk <= {blk[503:0], shift_byte};
    end else if (cmd.round_en) begin
      blk <= {blk[479:0], w_new};
    end
    if (cmd.load_vars) begin
      for (int j = 0; j < 8; j++) begin
        vars[j] <= chain[j];
      end
    end else if (cmd.round_en) begin
      vars[7] <= vars[6];
      vars[6] <= vars[5];
      vars[5] <= vars[4];
      vars[4] <= vars[3] + t1;
      vars[3] <= vars[2];
      vars[2] <= vars[1];
      vars[1] <= vars[0];
      vars[0] <= t1 + t2;
    end
    if (cmd.finish) begin
      for (int j = 0; j < 8; j++) begin
        dig[j] <= chain[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < 8; j++) begin
        chain[j] <= shash_pkg::init_word(3'(j));
      end
      count    <= '0;
      bitlen   <= '0;
      out_busy <= 1'b0;
      out_idx  <= '0;
    end else begin
      if (cmd.shift_en) begin
        count <= count + 6'd1;
        if (cmd.byte_sel == shash_pkg::BSEL_INPUT) begin
          bitlen <= bitlen + 64'd8;
        end
      end
      if (cmd.update_chain) begin
        for (int j = 0; j < 8; j++) begin
          chain[j] <= chain[j] + vars[j];
        end
      end
      if (cmd.finish) begin
        for (int j = 0; j < 8; j++) begin
          chain[j] <= shash_pkg::init_word(3'(j));
        end
        bitlen   <= '0;
        out_busy <= 1'b1;
        out_idx  <= '0;
      end else if (out_busy && out_ready) begin
        out_idx <= out_idx + 3'd1;
        if (out_idx == 3'd7) begin
          out_busy <= 1'b0;
        end
      end
    end
  end

  assign status.count_full  = (count == 6'd63);
  assign status.count_ge_56 = (count[5:3] == 3'b111);
  assign status.out_busy    = out_busy;

  assign out_valid = out_busy;
  assign out_word  = dig[out_idx];
  assign out_index = out_idx;
  assign out_last  = (out_idx == 3'd7);

  a_finish_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !out_busy)
    else $error("digest overwritten while still being sent");

  a_out_starts_at_h0: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> (out_busy && out_idx == 3'd0))
    else $error("digest output did not start at word zero");

  a_len_in_tail: assert property (@(posedge clk) disable iff (rst)
    (cmd.shift_en && cmd.byte_sel == shash_pkg::BSEL_LEN) |-> (count[5:3] == 3'b111))
    else $error("length byte outside the last eight block bytes");

endmodule

>>> hw/rtl/sha256_stream_hasher_core.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher_core
// Byte-stream SHA-256 hasher: at most one message byte per request, digest out as
// eight 32-bit words.
// ----------------------------------------------------------------------------
// intake: a byte request is taken only while idle; every 64th byte starts a
//   compression: load, 64 rounds in the single round unit, chaining update
// end of message: padding bytes are shifted in up to the 64th, each padded
//   block is compressed, and the digest moves into the output buffer once free
// compression runs the one-round-per-cycle unit and takes no new byte meanwhile;
//   digest words leave at 1 per cycle from an output buffer while the sink is
//   ready, while the next message is taken in
// reset: synchronous, loads the initial hash values and clears counters;
//   no clearing pass, the block register is fully written before use
module sha256_stream_hasher_core (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] byte_present
  input  logic        s_axis_tlast,   // end_of_message
  // digest stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index, rest zero
  output logic        m_axis_tlast    // last_word
);

  shash_pkg::dp_cmd_t    cmd;
  shash_pkg::dp_status_t status;
  shash_pkg::word_t      out_word;
  logic [2:0]            out_index;

  // sequencer: decides per cycle whether to shift, pad, load, run a round, update the chain or finish
  shash_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_present (s_axis_tuser),
    .in_last    (s_axis_tlast),
    .in_ready   (s_axis_tready),
    .status     (status),
    .cmd        (cmd)
  );

  // datapath: block shift register doubles as the message schedule window
  shash_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_byte   (s_axis_tdata),
    .cmd       (cmd),
    .status    (status),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_word  (out_word),
    .out_index (out_index),
    .out_last  (m_axis_tlast)
  );

  // digest word in the low bits, its index above, zero fill to whole bytes
  assign m_axis_tdata = {5'b00000, out_index, out_word};

endmodule

>>> tb/sv/tb_sha256_stream_hasher_core.sv
// ----------------------------------------------------------------------------
// tb_sha256_stream_hasher_core
// Feeds byte-stream messages into the hasher with random gaps on both sides
// and checks every digest word against a SHA-256 digest computed in the bench.
// ----------------------------------------------------------------------------
module tb_sha256_stream_hasher_core;

  localparam int STALL_LIMIT = 2000;
  localparam int ITEM_TARGET = 370;
  localparam int TAIL_CYCLES = 200;

  localparam shash_pkg::word_t IV_WORDS [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam shash_pkg::word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct {
    shash_pkg::word_t word;
    logic [2:0]       idx;
    logic             last;
  } digest_word_t;

  // running SHA-256 of the message in flight plus the digest words owed
  class digest_tracker;
    shash_pkg::word_t chain [8];
    logic [7:0]       blk [64];
    int unsigned      fill;
    logic [63:0]      bit_len;
    digest_word_t     expected_words [$];
    int unsigned      errors;

    function new();
      chain = IV_WORDS;
      foreach (blk[i]) blk[i] = 8'h00;
      fill = 0;
      bit_len = '0;
      errors = 0;
    endfunction

    function shash_pkg::word_t rotr(shash_pkg::word_t x, int unsigned n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void compress();
      shash_pkg::word_t w [16];
      shash_pkg::word_t v [8];
      shash_pkg::word_t t1, t2, wt, s0, s1;
      for (int t = 0; t < 16; t++)
        w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
      v = chain;
      for (int t = 0; t < 64; t++) begin
        if (t < 16) begin
          wt = w[t];
        end else begin
          s0 = rotr(w[(t-15)%16], 7) ^ rotr(w[(t-15)%16], 18) ^ (w[(t-15)%16] >> 3);
          s1 = rotr(w[(t-2)%16], 17) ^ rotr(w[(t-2)%16], 19) ^ (w[(t-2)%16] >> 10);
          wt = w[t%16] + s0 + w[(t-7)%16] + s1;
          w[t%16] = wt;
        end
        t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25)) +
             ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[t] + wt;
        t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22)) +
             ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6];
        v[6] = v[5];
        v[5] = v[4];
        v[4] = v[3] + t1;
        v[3] = v[2];
        v[2] = v[1];
        v[1] = v[0];
        v[0] = t1 + t2;
      end
      for (int j = 0; j < 8; j++) chain[j] = chain[j] + v[j];
    endfunction

    // one accepted request: absorb the byte if present, and on end of message pad and
    // queue the eight digest words
    function void take_request(logic [7:0] data_byte, logic present, logic eom);
      digest_word_t e;
      if (present) begin
        blk[fill] = data_byte;
        fill++;
        bit_len = bit_len + 64'd8;
        if (fill == 64) begin
          compress();
          fill = 0;
        end
      end
      if (!eom) return;
      blk[fill] = 8'h80;
      for (int i = fill + 1; i < 64; i++) blk[i] = 8'h00;
      // no room left for the length, so it goes into an extra block
      if (fill >= 56) begin
        compress();
        foreach (blk[i]) blk[i] = 8'h00;
      end
      for (int i = 0; i < 8; i++) blk[56+i] = bit_len[63 - 8*i -: 8];
      compress();
      for (int i = 0; i < 8; i++) begin
        e.word = chain[i];
        e.idx  = 3'(i);
        e.last = (i == 7);
        expected_words.push_back(e);
      end
      chain = IV_WORDS;
      fill = 0;
      bit_len = '0;
    endfunction

    function void check_word(logic [39:0] data, logic last_flag);
      digest_word_t e;
      if (expected_words.size() == 0) begin
        $error("unexpected digest word %h", data[31:0]);
        errors++;
        return;
      end
      e = expected_words.pop_front();
      if (data[31:0] !== e.word) begin
        $error("digest_word: expected %h, got %h", e.word, data[31:0]);
        errors++;
      end
      if (data[34:32] !== e.idx) begin
        $error("word_index: expected %0d, got %0d", e.idx, data[34:32]);
        errors++;
      end
      if (last_flag !== e.last) begin
        $error("last_word: expected %b, got %b", e.last, last_flag);
        errors++;
      end
      if (data[39:35] !== 5'd0) begin
        $error("tdata padding: expected %h, got %h", 5'd0, data[39:35]);
        errors++;
      end
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tuser = 1'b0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;

  digest_tracker tracker = new();
  int unsigned   items_sent = 0;
  int unsigned   quiet_cycles = 0;
  bit            steady = 1'b0;

  sha256_stream_hasher_core dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // digest sink: random back-pressure, none during the steady stretch
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= steady || ($urandom_range(0, 99) >= 23);
    end
  end

  // sample mid-cycle, where everything is settled before the next edge
  always @(negedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) tracker.check_word(m_axis_tdata, m_axis_tlast);
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
        quiet_cycles = 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
        $display("sha256_stream_hasher_core test failed");
        $finish;
      end else begin
        quiet_cycles++;
      end
    end
  end

  task automatic send_request(input logic [7:0] data_byte, input logic present,
                              input logic eom);
    bit taken;
    while (!steady && $urandom_range(0, 99) < 23) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data_byte;
    s_axis_tuser  <= present;
    s_axis_tlast  <= eom;
    do begin
      @(negedge clk);
      taken = s_axis_tready;
      @(posedge clk);
    end while (!taken);
    tracker.take_request(data_byte, present, eom);
    items_sent++;
  endtask

  // a message of len bytes; either the last byte carries the end marker or
  // a byteless request closes it; stray empty requests are mixed in
  task automatic send_message(input int unsigned len, input bit empty_end);
    logic [7:0] b;
    for (int unsigned k = 0; k < len; k++) begin
      if ($urandom_range(0, 99) < 8) send_request(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      if ($urandom_range(0, 9) == 0) b = {8{$urandom_range(0, 1) == 1}};
      else b = 8'($urandom_range(0, 255));
      send_request(b, 1'b1, (k == len - 1) && !empty_end);
    end
    if (len == 0 || empty_end) send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  initial begin
    int unsigned len;
    int unsigned pick;
    int unsigned boundary_lens [6];

    boundary_lens = '{55, 56, 57, 63, 64, 65};

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // empty message
    send_request(8'h5a, 1'b0, 1'b1);
    // ignored request, then a single zero byte with the end marker
    send_request(8'hff, 1'b0, 1'b0);
    send_request(8'h00, 1'b1, 1'b1);
    // "abc"
    send_request(8'h61, 1'b1, 1'b0);
    send_request(8'h62, 1'b1, 1'b0);
    send_request(8'h63, 1'b1, 1'b1);
    // bytes, an ignored request in between, closed by a byteless end; then a one-byte message
    send_request(8'hff, 1'b1, 1'b0);
    send_request(8'h00, 1'b1, 1'b0);
    send_request(8'h33, 1'b0, 1'b0);
    send_request(8'h80, 1'b1, 1'b0);
    send_request(8'h7f, 1'b1, 1'b0);
    send_request(8'hc3, 1'b0, 1'b1);
    send_request(8'hff, 1'b1, 1'b1);
    // wrap of the 64-bit bit count would take 2^61 bytes, out of reach here

    // random messages: short ones, lengths around the padding and block
    // boundaries, and longer ones of 13 to 130 bytes
    while (items_sent < ITEM_TARGET) begin
      steady = (items_sent >= 150 && items_sent < 230);
      pick = $urandom_range(0, 99);
      if (pick < 55) len = $urandom_range(0, 12);
      else if (pick < 80) len = boundary_lens[$urandom_range(0, 5)];
      else len = $urandom_range(13, 130);
      // limit the last message's byte count to the remaining request budget
      if (items_sent + len > ITEM_TARGET) len = ITEM_TARGET - items_sent;
      send_message(len, $urandom_range(0, 3) == 0);
    end
    steady = 1'b0;
    s_axis_tvalid <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("sha256_stream_hasher_core test passed");
    end else begin
      $display("sha256_stream_hasher_core test failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/shash_pkg.sv
hw/rtl/shash_ctrl.sv
hw/rtl/shash_dp.sv
hw/rtl/sha256_stream_hasher_core.sv
tb/sv/tb_sha256_stream_hasher_core.sv
